// ===== rtl/core/code_range_map_lookup_top_macros.svh =====
// ----------------------------------------------------------------------------
// Code range map lookup - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CODE_RANGE_MAP_LOOKUP_TOP_MACROS_SVH
`define CODE_RANGE_MAP_LOOKUP_TOP_MACROS_SVH

// General property check, disabled while rst_ni is low.
`define CRML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when cond holds, expect must hold in the same cycle.
`define CRML_ASSERT_IMPL(lbl, cond, expect_expr, msg) \
  `CRML_ASSERT(lbl, (cond) |-> (expect_expr), msg)

`endif

// ===== rtl/core/crml_pkg.sv =====
// ----------------------------------------------------------------------------
// crml_pkg
// Types, codes and sizes shared by the code range map lookup block.
// ----------------------------------------------------------------------------
package crml_pkg;

  // Storage sizes
  localparam int MaxCells   = 64;
  localparam int TableWords = 4096;   // power of two
  localparam int CellAw     = (MaxCells > 1) ? $clog2(MaxCells) : 1;
  localparam int CellCntW   = $clog2(MaxCells + 1);
  localparam int TblAw      = $clog2(TableWords);

  // Configuration register widths and reset values
  localparam int              CountW       = 7;
  localparam int              CodeW        = 16;
  localparam logic [CodeW-1:0] NoMapReset  = 16'hFFFD;
  localparam int              PaddrW       = 3;
  localparam int              PdataW       = 32;

  // Register index (paddr[2])
  typedef enum logic {
    REG_CELL_COUNT = 1'b0,
    REG_NO_MAPPING = 1'b1
  } reg_e;

  // Request opcodes; code 3 is ignored
  typedef enum logic [1:0] {
    OP_WRITE_CELL = 2'd0,
    OP_WRITE_WORD = 2'd1,
    OP_LOOKUP     = 2'd2
  } op_e;

  // Cell formats; codes 3..15 never hit
  typedef enum logic [3:0] {
    FMT_RANGE  = 4'd0,
    FMT_TABLE  = 4'd1,
    FMT_SINGLE = 4'd2
  } fmt_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [11:0]      slot;
    logic [3:0]       cell_format;
    logic [CodeW-1:0] src_begin;
    logic [CodeW-1:0] src_end;
    logic [CodeW-1:0] dest_or_offset;
    logic [CodeW-1:0] code;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [CodeW-1:0] out_code;
  } rsp_t;

  // One mapping cell as stored (52 bits)
  typedef struct packed {
    logic [3:0]       fmt;
    logic [CodeW-1:0] lo;
    logic [CodeW-1:0] hi;
    logic [CodeW-1:0] dest;
  } cell_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_TBL_RD,
    ST_TBL_WAIT,
    ST_RESULT
  } state_e;

endpackage

// ===== rtl/core/code_range_map_lookup_top.sv =====
// ----------------------------------------------------------------------------
// code_range_map_lookup_top
// Maps 16-bit character codes through a loaded list of range cells and a
// mapping table; one request writes a cell, writes a table word or looks up.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Transfer when
//  --------+-------------------------------------------+------------------------
//  in      | in_valid_i, in_stall_o, in_req_i          | valid high, stall low
//  out     | out_valid_o, out_stall_i, out_rsp_o       | valid high, stall low
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | psel, penable, pwrite
//
//  Cell and table writes and op 3 (dropped) never hold the input stalled.
//  A lookup stalls the input while it scans cells (1..64, one per cycle
//  through the single read port of the cell memory; none for an empty cell
//  list), while a hitting table cell reads the mapping table and until its result is loaded.
//  Reset clears the sequencer state, the output valid flag and the config registers;
//  cell and table memories are not cleared and hold garbage until written.
//  The output register decouples the sides: a new request is taken while a
//  result waits, and only the next lookup result waits on out_stall_i.
// ----------------------------------------------------------------------------
`include "code_range_map_lookup_top_macros.svh"

module code_range_map_lookup_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  crml_pkg::req_t                    in_req_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output crml_pkg::rsp_t                    out_rsp_o,
  // APB-style config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [crml_pkg::PaddrW-1:0]       paddr,
  input  logic [crml_pkg::PdataW-1:0]       pwdata,
  output logic [crml_pkg::PdataW-1:0]       prdata,
  output logic                              pready
);
  import crml_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CountW-1:0] cell_count_q;
  logic [CodeW-1:0]  no_map_q;
  logic              cfg_we;
  reg_e              cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= '0;
      no_map_q     <= NoMapReset;
    end else if (cfg_we) begin
      case (cfg_sel)
        REG_CELL_COUNT: cell_count_q <= pwdata[CountW-1:0];
        REG_NO_MAPPING: no_map_q     <= pwdata[CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_CELL_COUNT: prdata = PdataW'(cell_count_q);
      REG_NO_MAPPING: prdata = PdataW'(no_map_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic        in_acc;
  logic [31:0] slot_ext;
  logic        cell_we;
  logic        tbl_we;
  logic        lookup_acc;
  cell_t       cell_wdata;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign slot_ext   = 32'(in_req_i.slot);
  assign cell_we    = in_acc && (in_req_i.op == OP_WRITE_CELL) && (slot_ext < 32'(MaxCells));
  assign tbl_we     = in_acc && (in_req_i.op == OP_WRITE_WORD)
                      && (slot_ext < 32'(TableWords));
  assign lookup_acc = in_acc && (in_req_i.op == OP_LOOKUP);

  assign cell_wdata.fmt  = in_req_i.cell_format;
  assign cell_wdata.lo   = in_req_i.src_begin;
  assign cell_wdata.hi   = in_req_i.src_end;
  assign cell_wdata.dest = in_req_i.dest_or_offset;

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [CellCntW-1:0] idx_q, idx_d;     // next cell to fetch
  logic [CellCntW-1:0] n_q, n_d;         // cells to scan (clamped count)
  logic [CodeW-1:0]    code_q, code_d;
  logic                hit_q, hit_d;
  logic [CodeW-1:0]    res_q, res_d;
  logic [TblAw-1:0]    taddr_q, taddr_d;
  logic [CellCntW-1:0] n_clamp;

  assign n_clamp = (32'(cell_count_q) > 32'(MaxCells)) ? CellCntW'(MaxCells)
                                                       : CellCntW'(cell_count_q);

  // --------------------------------------------------------------------------
  // Memories: one write and one registered read port each
  // --------------------------------------------------------------------------
  cell_t            cell_mem [MaxCells];
  cell_t            cell_rd_q;
  logic [CodeW-1:0] tbl_mem [TableWords];
  logic [CodeW-1:0] tbl_rd_q;

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[slot_ext[CellAw-1:0]] <= cell_wdata;
    end
    cell_rd_q <= cell_mem[idx_q[CellAw-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[slot_ext[TblAw-1:0]] <= in_req_i.code;
    end
    tbl_rd_q <= tbl_mem[taddr_q];
  end

  // --------------------------------------------------------------------------
  // Shared compare/offset unit: tests the cell fetched last cycle
  // --------------------------------------------------------------------------
  logic             cu_hit;
  logic [CodeW-1:0] cu_delta;
  logic [CodeW-1:0] cu_sum;

  assign cu_delta = code_q - cell_rd_q.lo;
  assign cu_sum   = cu_delta + cell_rd_q.dest;   // wraps at 16 bits

  always_comb begin
    case (fmt_e'(cell_rd_q.fmt))
      FMT_RANGE,
      FMT_TABLE:  cu_hit = (code_q >= cell_rd_q.lo) && (code_q <= cell_rd_q.hi);
      FMT_SINGLE: cu_hit = (code_q == cell_rd_q.lo);
      default:    cu_hit = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic out_valid_q;
  rsp_t out_rsp_q;
  logic out_load;

  assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q.found    <= hit_q && (res_q != no_map_q);
      out_rsp_q.out_code <= res_q;
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    n_d     = n_q;
    code_d  = code_q;
    hit_d   = hit_q;
    res_d   = res_q;
    taddr_d = taddr_q;
    case (state_q)
      ST_IDLE: begin
        if (lookup_acc) begin
          code_d = in_req_i.code;
          n_d    = n_clamp;
          idx_d  = '0;
          hit_d  = 1'b0;
          res_d  = '0;
          state_d = (n_clamp == '0) ? ST_RESULT : ST_PRIME;
        end
      end
      ST_PRIME: begin
        // cell 0 is being read this cycle
        idx_d   = idx_q + 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        // cell_rd_q holds cell idx_q-1
        if (cu_hit) begin
          hit_d = 1'b1;
          case (fmt_e'(cell_rd_q.fmt))
            FMT_RANGE: begin
              res_d   = cu_sum;
              state_d = ST_RESULT;
            end
            FMT_TABLE: begin
              taddr_d = cu_sum[TblAw-1:0];
              state_d = ST_TBL_RD;
            end
            default: begin
              res_d   = cell_rd_q.dest;
              state_d = ST_RESULT;
            end
          endcase
        end else if (idx_q == n_q) begin
          state_d = ST_RESULT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TBL_RD: begin
        state_d = ST_TBL_WAIT;
      end
      ST_TBL_WAIT: begin
        res_d   = tbl_rd_q;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    hit_q   <= hit_d;
    res_q   <= res_d;
    taddr_q <= taddr_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CRML_ASSERT_IMPL(a_scan_bound, state_q == ST_SCAN,
                    (idx_q != '0) && (idx_q <= n_q), "scan index out of range")
  `CRML_ASSERT(a_tbl_seq, (state_q == ST_TBL_WAIT) |-> ($past(state_q) == ST_TBL_RD),
               "table wait not preceded by table read")
  `CRML_ASSERT(a_lookup_next, lookup_acc |=> (state_q == ST_PRIME || state_q == ST_RESULT),
               "lookup did not start scan or finish")
  `CRML_ASSERT(a_out_from_result, $rose(out_valid_o) |-> ($past(state_q) == ST_RESULT),
               "result appeared outside result state")
  `CRML_ASSERT_IMPL(a_miss_zero, (state_q == ST_RESULT) && !hit_q,
                    res_q == '0, "miss carries nonzero code")

endmodule

// ===== test/tb_code_range_map_lookup_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_code_range_map_lookup_top
// Self-checking bench for the code range map lookup block. A queue of
// requests feeds a clocked driver. A shadow of the cell list and the mapping
// table predicts each lookup result, and a clocked monitor checks it. Config
// goes through the APB port between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_code_range_map_lookup_top;
  import crml_pkg::*;

  localparam int         SETTLE_CYCLES  = 8;            // lets trailing write requests land
  localparam int         LOOKUP_CYCLES  = MaxCells + 4; // full scan plus table read
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_PHASES  = 8;
  localparam int         PHASE_REQS     = 40;
  localparam int         PLAN           = 0;            // shadow copy used while generating
  localparam int         PRED           = 1;            // shadow copy used at acceptance
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [3:0] FMT_NEVER      = 4'hF;

  typedef struct {
    req_t req;
    bit   drain_first;  // hold this request until all results are back
  } pending_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  req_t                in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rsp_t                out_rsp_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PaddrW-1:0]   paddr       = '0;
  logic [PdataW-1:0]   pwdata      = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  // Two shadows of the cell list: one runs ahead with generation, one
  // follows the requests the block has actually taken.
  cell_t               cell_mem [2][MaxCells];
  logic [CodeW-1:0]    word_mem [TableWords];
  bit                  cell_written [MaxCells];
  bit                  word_written [TableWords];
  logic [CountW-1:0]   plan_count = '0;
  logic [CountW-1:0]   pred_count = '0;
  logic [CodeW-1:0]    plan_nomap = NoMapReset;
  logic [CodeW-1:0]    pred_nomap = NoMapReset;

  pending_t            pending_reqs [$];
  rsp_t                predicted_rsp [$];

  int n_queued     = 0;
  int n_accepted   = 0;
  int n_expected   = 0;
  int n_received   = 0;
  int n_errors     = 0;
  int n_cfg_writes = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int idle_cycles  = 0;
  bit quiet        = 1'b0;  // no idling on either side

  code_range_map_lookup_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Mapping model
  // --------------------------------------------------------------------------

  // Index of the first cell among the scanned ones that covers v, else -1.
  function automatic int first_hit(input int copy, input logic [CodeW-1:0] v,
                                   input logic [CountW-1:0] count);
    int    n;
    cell_t c;
    n = (int'(count) > MaxCells) ? MaxCells : int'(count);
    for (int i = 0; i < n; i++) begin
      c = cell_mem[copy][i];
      if (((c.fmt == FMT_RANGE || c.fmt == FMT_TABLE) && v >= c.lo && v <= c.hi) ||
          (c.fmt == FMT_SINGLE && v == c.lo))
        return i;
    end
    return -1;
  endfunction

  // Table address of a range-via-table cell; the sum wraps at the table size.
  function automatic logic [TblAw-1:0] table_addr(input cell_t c, input logic [CodeW-1:0] v);
    logic [CodeW-1:0] sum;
    sum = c.dest + (v - c.lo);
    return sum[TblAw-1:0];
  endfunction

  // Apply one accepted request to the shadow state; lookups yield a result.
  function automatic void map_request(input req_t r, output bit has_rsp, output rsp_t rsp);
    int               hit;
    cell_t            c;
    logic [CodeW-1:0] res;
    has_rsp = 1'b0;
    rsp     = '0;
    case (r.op)
      OP_WRITE_CELL: begin
        // slots past the cell list are dropped
        if (r.slot < 12'(MaxCells))
          cell_mem[PRED][r.slot[CellAw-1:0]] =
            {r.cell_format, r.src_begin, r.src_end, r.dest_or_offset};
      end
      OP_WRITE_WORD: begin
        word_mem[r.slot] = r.code;  // 12-bit slot always fits the table
      end
      OP_LOOKUP: begin
        has_rsp = 1'b1;
        hit     = first_hit(PRED, r.code, pred_count);
        if (hit >= 0) begin
          c = cell_mem[PRED][hit];
          if (c.fmt == FMT_RANGE)      res = (r.code - c.lo) + c.dest;
          else if (c.fmt == FMT_TABLE) res = word_mem[table_addr(c, r.code)];
          else                         res = c.dest;
          rsp.found    = (res != pred_nomap);
          rsp.out_code = res;
        end
      end
      default: ;  // unused op is dropped
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request generation
  // --------------------------------------------------------------------------

  function automatic req_t rand_req();
    req_t r;
    r.op             = 2'($urandom);
    r.slot           = 12'($urandom);
    r.cell_format    = 4'($urandom);
    r.src_begin      = 16'($urandom);
    r.src_end        = 16'($urandom);
    r.dest_or_offset = 16'($urandom);
    r.code           = 16'($urandom);
    return r;
  endfunction

  task automatic queue_req(input req_t r, input bit drain);
    pending_t p;
    p.req         = r;
    p.drain_first = drain;
    pending_reqs.push_back(p);
    n_queued++;
    if (r.op == OP_WRITE_CELL && r.slot < 12'(MaxCells)) begin
      cell_mem[PLAN][r.slot[CellAw-1:0]] =
        {r.cell_format, r.src_begin, r.src_end, r.dest_or_offset};
      cell_written[r.slot[CellAw-1:0]] = 1'b1;
    end else if (r.op == OP_WRITE_WORD) begin
      word_written[r.slot] = 1'b1;
    end
  endtask

  task automatic queue_cell(input logic [11:0] slot, input logic [3:0] fmt,
                            input logic [CodeW-1:0] lo, input logic [CodeW-1:0] hi,
                            input logic [CodeW-1:0] dest);
    req_t r;
    r                = rand_req();
    r.op             = OP_WRITE_CELL;
    r.slot           = slot;
    r.cell_format    = fmt;
    r.src_begin      = lo;
    r.src_end        = hi;
    r.dest_or_offset = dest;
    queue_req(r, 1'b0);
  endtask

  task automatic queue_word(input logic [TblAw-1:0] addr, input logic [CodeW-1:0] data);
    req_t r;
    r      = rand_req();
    r.op   = OP_WRITE_WORD;
    r.slot = addr;
    r.code = data;
    queue_req(r, 1'b0);
  endtask

  task automatic queue_lookup(input logic [CodeW-1:0] code, input bit drain);
    req_t             r;
    int               hit;
    logic [TblAw-1:0] a;
    hit = first_hit(PLAN, code, plan_count);
    if (hit >= 0 && cell_mem[PLAN][hit].fmt == FMT_TABLE) begin
      a = table_addr(cell_mem[PLAN][hit], code);
      // never read a table word that holds garbage
      if (!word_written[a])
        queue_word(a, ($urandom_range(0, 5) == 0) ? plan_nomap : 16'($urandom));
    end
    r      = rand_req();
    r.op   = OP_LOOKUP;
    r.code = code;
    queue_req(r, drain);
  endtask

  task automatic queue_rand_cell(input logic [11:0] slot);
    int               k;
    logic [3:0]       fmt;
    logic [CodeW-1:0] lo;
    logic [CodeW-1:0] hi;
    logic [CodeW-1:0] dest;
    k = $urandom_range(0, 19);
    if (k < 6)       fmt = FMT_RANGE;
    else if (k < 12) fmt = FMT_TABLE;
    else if (k < 17) fmt = FMT_SINGLE;
    else             fmt = 4'($urandom_range(3, 15));
    lo = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       hi = 16'($urandom);
      1:       hi = lo;
      2:       hi = lo - 16'($urandom_range(1, 40));  // mostly an empty range
      default: hi = lo + 16'($urandom_range(0, 40));
    endcase
    dest = ($urandom_range(0, 9) == 0) ? plan_nomap : 16'($urandom);
    queue_cell(slot, fmt, lo, hi, dest);
  endtask

  task automatic queue_rand_item();
    int               k;
    int               n;
    req_t             r;
    cell_t            c;
    logic [CodeW-1:0] code;
    k = $urandom_range(0, 99);
    if (k < 12) begin
      queue_rand_cell(($urandom_range(0, 7) == 0) ? 12'($urandom)
                                                  : 12'($urandom_range(0, MaxCells - 1)));
    end else if (k < 22) begin
      queue_word(12'($urandom), ($urandom_range(0, 5) == 0) ? plan_nomap : 16'($urandom));
    end else if (k < 26) begin
      r    = rand_req();
      r.op = OP_UNUSED;
      queue_req(r, 1'b0);
    end else begin
      // most lookups aim inside a scanned cell, the rest are arbitrary codes
      n    = (int'(plan_count) > MaxCells) ? MaxCells : int'(plan_count);
      code = 16'($urandom);
      if (n > 0 && $urandom_range(0, 9) < 7) begin
        c    = cell_mem[PLAN][$urandom_range(0, n - 1)];
        code = (c.hi >= c.lo) ? c.lo + 16'($urandom_range(0, int'(c.hi - c.lo))) : c.lo;
      end
      queue_lookup(code, $urandom_range(0, 39) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Config port and phase control
  // --------------------------------------------------------------------------

  task automatic reg_write(input reg_e idx, input logic [PdataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CELL_COUNT) begin
      pred_count = value[CountW-1:0];
      plan_count = value[CountW-1:0];
    end else begin
      pred_nomap = value[CodeW-1:0];
      plan_nomap = value[CodeW-1:0];
    end
    n_cfg_writes++;
  endtask

  // Every request taken and every result back, then let trailing writes land.
  task automatic wait_idle(input int extra);
    while (n_accepted != n_queued || n_received < n_expected) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h, predicted 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: pops the pending queue, random gaps between requests.
  // A stalled request is held untouched; valid is assigned once per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    rsp_t     rsp;
    bit       has_rsp;
    bit       outstanding;
    pending_t nxt;
    if (rst_ni) begin
      outstanding = (n_received < n_expected);
      if (in_valid_i && !in_stall_o) begin
        map_request(in_req_i, has_rsp, rsp);
        if (has_rsp) begin
          predicted_rsp.push_back(rsp);
          n_expected <= n_expected + 1;
          outstanding = 1'b1;
        end
        n_accepted <= n_accepted + 1;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain_first && outstanding)) begin
          nxt = pending_reqs.pop_front();
          in_req_i   <= nxt.req;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each taken result against the oldest prediction
  // and stalls the result channel in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_received <= n_received + 1;
        if (predicted_rsp.size() == 0) begin
          report_mismatch("result with no lookup pending", 32'(out_rsp_o), 32'(0));
        end else begin
          want = predicted_rsp.pop_front();
          if (out_rsp_o.found !== want.found)
            report_mismatch("found", 32'(out_rsp_o.found), 32'(want.found));
          if (out_rsp_o.out_code !== want.out_code)
            report_mismatch("out_code", 32'(out_rsp_o.out_code), 32'(want.out_code));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transfer on any port ends the run.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, n_expected - n_received);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed cases, then random phases with a config change each.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               count;
    logic [CodeW-1:0] nomap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset config: empty cell list, so every lookup misses.
    queue_lookup(16'h0000, 1'b0);
    queue_cell(12'd0, FMT_SINGLE, 16'h0041, 16'h0000, NoMapReset);  // maps to no-mapping
    queue_cell(12'd1, FMT_RANGE,  16'h1000, 16'h0FFF, 16'h1234);    // empty range
    queue_cell(12'd2, FMT_RANGE,  16'hFFF0, 16'hFFFF, 16'hFFF8);    // sum wraps 16 bits
    queue_cell(12'd3, FMT_TABLE,  16'h0100, 16'h01FF, 16'h0FF0);    // address wraps
    queue_cell(12'd4, FMT_NEVER,  16'h0000, 16'hFFFF, 16'h7777);    // format never hits
    queue_cell(12'd5, FMT_RANGE,  16'h0000, 16'hFFFF, 16'h0000);    // identity catch-all
    // out-of-range cell slots: must not alias onto cells 5 and 63
    queue_cell(12'(MaxCells + 5), FMT_SINGLE, 16'h2222, 16'h2222, 16'hBEEF);
    queue_cell(12'hFFF, FMT_SINGLE, 16'h0000, 16'h0000, 16'hDEAD);
    queue_word(12'h010, 16'hABCD);
    queue_word(12'hFFF, 16'h5A5A);
    begin : unused_op
      req_t r;
      r    = rand_req();
      r.op = OP_UNUSED;
      queue_req(r, 1'b0);
    end
    queue_lookup(16'h0041, 1'b0);

    // Six cells, no-mapping value still at reset.
    wait_idle(SETTLE_CYCLES);
    reg_write(REG_CELL_COUNT, 32'd6);
    queue_lookup(16'h0041, 1'b0);   // hit, equals no-mapping
    queue_lookup(16'h1000, 1'b0);   // skips empty range
    queue_lookup(16'hFFFF, 1'b0);
    queue_lookup(16'hFFF0, 1'b1);   // sender waits for all results first
    queue_lookup(16'h0120, 1'b0);
    queue_lookup(16'h010F, 1'b0);   // last table word
    queue_lookup(16'h2222, 1'b0);
    queue_lookup(16'h0000, 1'b0);

    wait_idle(SETTLE_CYCLES);
    reg_write(REG_NO_MAPPING, 32'h0000_1000);
    queue_lookup(16'h1000, 1'b0);
    queue_lookup(16'h0041, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle(SETTLE_CYCLES);
      case (p)
        0: begin
          // only cells written so far may be scanned
          count = 0;
          while (count < MaxCells && cell_written[count]) count++;
        end
        1:       count = MaxCells;
        2:       count = 127;
        3:       count = 0;
        4:       count = 1;
        5:       count = $urandom_range(2, MaxCells - 1);
        6:       count = $urandom_range(MaxCells + 1, 126);
        default: count = MaxCells;
      endcase
      case (p % 4)
        1:       nomap = 16'hFFFF;
        2:       nomap = 16'h0000;
        default: nomap = 16'($urandom);
      endcase
      reg_write(REG_CELL_COUNT, {25'($urandom), 7'(count)});
      reg_write(REG_NO_MAPPING, {16'($urandom), nomap});
      if (p == RANDOM_PHASES - 1) quiet <= 1'b1;
      if (p == 0)
        for (int s = 0; s < MaxCells; s++) queue_rand_cell(12'(s));  // load the whole list
      for (int i = 0; i < PHASE_REQS; i++) queue_rand_item();
    end

    wait_idle(2 * LOOKUP_CYCLES);
    if (predicted_rsp.size() != 0)
      report_mismatch("lookup results never delivered", 32'(predicted_rsp.size()), 32'(0));

    $display("Run covered %0d requests, %0d lookup results checked, %0d register writes.",
             n_accepted, n_received, n_cfg_writes);
    $display("Cell counts 0 to 127, no-mapping extremes, all formats, ignored slots and op.");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
